// File: hdl/usv_pkg.sv
// shared types, constants and the forbidden code point table for the suggestion validator
`default_nettype none
package usv_pkg;

  localparam int unsigned SCALAR_W   = 21;
  localparam int unsigned SCOUNT_W   = 11;
  localparam int unsigned WCOUNT_W   = 9;
  localparam int unsigned MAXW_W     = 8;
  localparam int unsigned CFG_DATA_W = 11;

  localparam logic [SCOUNT_W-1:0] SCALAR_SAT = 11'd2047;
  localparam logic [WCOUNT_W-1:0] WORD_SAT   = 9'd511;

  localparam logic [SCOUNT_W-1:0] MAX_SCALARS_RST = 11'd64;
  localparam logic [MAXW_W-1:0]   MAX_WORDS_RST   = 8'd16;

  // configuration register indexes
  localparam logic REG_MAX_SCALARS = 1'b0;
  localparam logic REG_MAX_WORDS   = 1'b1;

  localparam logic [SCALAR_W-1:0] SCALAR_MAX = 21'h10ffff;
  localparam logic [SCALAR_W-1:0] SURR_LO    = 21'h00d800;
  localparam logic [SCALAR_W-1:0] SURR_HI    = 21'h00dfff;
  localparam logic [SCALAR_W-1:0] MIN_3BYTE  = 21'h000800;
  localparam logic [SCALAR_W-1:0] MIN_4BYTE  = 21'h010000;
  localparam logic [SCALAR_W-1:0] SPACE      = 21'h000020;

  localparam logic [7:0] LEAD2_LO = 8'hc2;
  localparam logic [7:0] LEAD2_HI = 8'hdf;
  localparam logic [7:0] LEAD3_LO = 8'he0;
  localparam logic [7:0] LEAD3_HI = 8'hef;
  localparam logic [7:0] LEAD4_LO = 8'hf0;
  localparam logic [7:0] LEAD4_HI = 8'hf4;

  typedef struct packed {
    logic [SCALAR_W-1:0] lo;
    logic [SCALAR_W-1:0] hi;
  } span_t;

  localparam int unsigned NUM_BANNED = 29;

  localparam span_t BANNED [NUM_BANNED] = '{
    '{21'h000000, 21'h00001f}, '{21'h00007f, 21'h00009f}, '{21'h0000a0, 21'h0000a0},
    '{21'h0000ad, 21'h0000ad}, '{21'h000600, 21'h000605}, '{21'h00061c, 21'h00061c},
    '{21'h0006dd, 21'h0006dd}, '{21'h00070f, 21'h00070f}, '{21'h000890, 21'h000891},
    '{21'h0008e2, 21'h0008e2}, '{21'h001680, 21'h001680}, '{21'h00180e, 21'h00180e},
    '{21'h002000, 21'h00200a}, '{21'h00200b, 21'h00200f}, '{21'h002028, 21'h00202e},
    '{21'h00202f, 21'h00202f}, '{21'h00205f, 21'h00205f}, '{21'h002060, 21'h002064},
    '{21'h002066, 21'h00206f}, '{21'h003000, 21'h003000}, '{21'h00feff, 21'h00feff},
    '{21'h00fff9, 21'h00fffb}, '{21'h0110bd, 21'h0110bd}, '{21'h0110cd, 21'h0110cd},
    '{21'h013430, 21'h01343f}, '{21'h01bca0, 21'h01bca3}, '{21'h01d173, 21'h01d17a},
    '{21'h0e0001, 21'h0e0001}, '{21'h0e0020, 21'h0e007f}
  };

  // decoder result for one byte
  typedef struct packed {
    logic                scalar_vld;
    logic [SCALAR_W-1:0] scalar;
    logic                err;
    logic                open;
  } dec_out_t;

  function automatic logic is_banned(input logic [SCALAR_W-1:0] s);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < NUM_BANNED; i++) begin
      if (s >= BANNED[i].lo && s <= BANNED[i].hi) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage
`default_nettype wire

// File: hdl/usv_utf8_dec.sv
// strict utf-8 decoder, one byte per step
`default_nettype none
module usv_utf8_dec (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            step,
  input  wire logic                            has_byte,
  input  wire logic [7:0]                      data_byte,
  input  wire logic                            last,
  output usv_pkg::dec_out_t                    dec_out
);

  logic [1:0]                     bytes_left_r, bytes_left_nxt;
  logic [1:0]                     seq_len_r, seq_len_nxt;
  logic [usv_pkg::SCALAR_W-1:0]   partial_r, partial_nxt;
  logic [usv_pkg::SCALAR_W-1:0]   cont;
  logic                           bad;

  assign cont = {partial_r[usv_pkg::SCALAR_W-7:0], data_byte[5:0]};

  always_comb begin
    bytes_left_nxt = bytes_left_r;
    seq_len_nxt    = seq_len_r;
    partial_nxt    = partial_r;
    dec_out        = '0;
    bad            = 1'b0;
    if (step && has_byte) begin
      if (bytes_left_r == 2'd0) begin
        if (!data_byte[7]) begin
          dec_out.scalar_vld = 1'b1;
          dec_out.scalar     = {13'd0, data_byte};
        end else if (data_byte >= usv_pkg::LEAD2_LO && data_byte <= usv_pkg::LEAD2_HI) begin
          partial_nxt    = {16'd0, data_byte[4:0]};
          seq_len_nxt    = 2'd1;
          bytes_left_nxt = 2'd1;
        end else if (data_byte >= usv_pkg::LEAD3_LO && data_byte <= usv_pkg::LEAD3_HI) begin
          partial_nxt    = {17'd0, data_byte[3:0]};
          seq_len_nxt    = 2'd2;
          bytes_left_nxt = 2'd2;
        end else if (data_byte >= usv_pkg::LEAD4_LO && data_byte <= usv_pkg::LEAD4_HI) begin
          partial_nxt    = {18'd0, data_byte[2:0]};
          seq_len_nxt    = 2'd3;
          bytes_left_nxt = 2'd3;
        end else begin
          dec_out.err = 1'b1;
        end
      end else if (data_byte[7:6] != 2'b10) begin
        dec_out.err    = 1'b1;
        bytes_left_nxt = 2'd0;
        seq_len_nxt    = 2'd0;
        partial_nxt    = '0;
      end else begin
        bytes_left_nxt = bytes_left_r - 2'd1;
        if (bytes_left_r == 2'd1) begin
          bad = (seq_len_r == 2'd2 && cont < usv_pkg::MIN_3BYTE) ||
                (seq_len_r == 2'd3 && cont < usv_pkg::MIN_4BYTE) ||
                (cont >= usv_pkg::SURR_LO && cont <= usv_pkg::SURR_HI) ||
                (cont > usv_pkg::SCALAR_MAX);
          dec_out.err        = bad;
          dec_out.scalar_vld = !bad;
          dec_out.scalar     = cont;
          seq_len_nxt        = 2'd0;
          partial_nxt        = '0;
        end else begin
          partial_nxt = cont;
        end
      end
    end
    dec_out.open = (bytes_left_nxt != 2'd0);
    if (step && last) begin
      bytes_left_nxt = 2'd0;
      seq_len_nxt    = 2'd0;
      partial_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r <= 2'd0;
      seq_len_r    <= 2'd0;
      partial_r    <= '0;
    end else begin
      bytes_left_r <= bytes_left_nxt;
      seq_len_r    <= seq_len_nxt;
      partial_r    <= partial_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hdl/utf8_suggestion_validator.sv
// top level: streaming utf-8 suggestion validator with string rules and limits
`default_nettype none
// Takes one byte word per cycle on the in_ stream and gives one accept word on the
// out_ stream for every input word with tlast set. in_tuser[0] says whether
// in_tdata holds a byte; a word with tlast and no byte ends the string as it stands.
// A word is decoded and checked while it sits in the input register, and the final
// word's verdict lands in the output register, which gives the accept word. A final
// word is held in the input register while the output register is full and not draining;
// otherwise a new word is taken every cycle. The limits max_scalars and max_words are to
// be written on the cfg_ port between strings; the block itself does not enforce this.
module utf8_suggestion_validator (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [7:0]                        in_tdata,   // data_byte
  input  wire logic [0:0]                        in_tuser,   // has_byte
  input  wire logic                              in_tlast,   // last
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [7:0]                             out_tdata,  // accept, zero pad
  input  wire logic                              cfg_we,
  input  wire logic [0:0]                        cfg_index,
  input  wire logic [usv_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  logic                            in_v_r;
  logic [7:0]                      in_byte_r;
  logic                            in_has_r;
  logic                            in_last_r;
  logic                            out_v_r;
  logic                            out_acc_r;
  logic                            go;

  logic [usv_pkg::SCOUNT_W-1:0]    max_scalars_r;
  logic [usv_pkg::MAXW_W-1:0]      max_words_r;

  logic [usv_pkg::SCOUNT_W-1:0]    scalar_count_r, scalar_count_nxt;
  logic [usv_pkg::WCOUNT_W-1:0]    word_count_r, word_count_nxt;
  logic                            in_word_r, in_word_nxt;
  logic                            seen_r, seen_nxt;
  logic                            prev_space_r, prev_space_nxt;
  logic                            rejected_r, rejected_nxt;
  logic                            ok;
  logic                            is_space;

  usv_pkg::dec_out_t               dec;

  assign go        = in_v_r && (!in_last_r || !out_v_r || out_tready);
  assign in_tready = !in_v_r || go;
  assign out_tvalid = out_v_r;
  assign out_tdata  = {7'd0, out_acc_r};

  usv_utf8_dec u_dec (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (go),
    .has_byte  (in_has_r),
    .data_byte (in_byte_r),
    .last      (in_last_r),
    .dec_out   (dec)
  );

  assign is_space = (dec.scalar == usv_pkg::SPACE);

  always_comb begin
    scalar_count_nxt = scalar_count_r;
    word_count_nxt   = word_count_r;
    in_word_nxt      = in_word_r;
    seen_nxt         = seen_r;
    prev_space_nxt   = prev_space_r;
    rejected_nxt     = rejected_r || dec.err;
    if (dec.scalar_vld) begin
      if (scalar_count_r >= usv_pkg::SCALAR_SAT) begin
        rejected_nxt = 1'b1;
      end else begin
        scalar_count_nxt = scalar_count_r + 11'd1;
      end
      if (usv_pkg::is_banned(dec.scalar)) begin
        rejected_nxt = 1'b1;
      end
      if (is_space) begin
        if (prev_space_r) begin
          rejected_nxt = 1'b1;
        end
        in_word_nxt = 1'b0;
      end else begin
        seen_nxt = 1'b1;
        if (!in_word_r && word_count_r < usv_pkg::WORD_SAT) begin
          word_count_nxt = word_count_r + 9'd1;
        end
        in_word_nxt = 1'b1;
      end
      prev_space_nxt = is_space;
    end
    ok = !rejected_nxt && !dec.open && (scalar_count_nxt != '0) &&
         (scalar_count_nxt <= max_scalars_r) && seen_nxt && !prev_space_nxt &&
         (word_count_nxt <= {1'b0, max_words_r});
    if (in_last_r) begin
      scalar_count_nxt = '0;
      word_count_nxt   = '0;
      in_word_nxt      = 1'b0;
      seen_nxt         = 1'b0;
      prev_space_nxt   = 1'b0;
      rejected_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r         <= 1'b0;
      out_v_r        <= 1'b0;
      max_scalars_r  <= usv_pkg::MAX_SCALARS_RST;
      max_words_r    <= usv_pkg::MAX_WORDS_RST;
      scalar_count_r <= '0;
      word_count_r   <= '0;
      in_word_r      <= 1'b0;
      seen_r         <= 1'b0;
      prev_space_r   <= 1'b0;
      rejected_r     <= 1'b0;
    end else begin
      if (in_tready) begin
        in_v_r <= in_tvalid;
      end
      if (go && in_last_r) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
      if (cfg_we) begin
        if (cfg_index == usv_pkg::REG_MAX_SCALARS) begin
          max_scalars_r <= cfg_wdata;
        end else begin
          max_words_r <= cfg_wdata[usv_pkg::MAXW_W-1:0];
        end
      end
      if (go) begin
        scalar_count_r <= scalar_count_nxt;
        word_count_r   <= word_count_nxt;
        in_word_r      <= in_word_nxt;
        seen_r         <= seen_nxt;
        prev_space_r   <= prev_space_nxt;
        rejected_r     <= rejected_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_has_r  <= in_tuser[0];
      in_last_r <= in_tlast;
    end
    if (go && in_last_r) begin
      out_acc_r <= ok;
    end
  end

`ifndef SYNTH
  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(go && in_last_r))
    else $error("result appeared without a final word");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (go && in_last_r) |=> (scalar_count_r == '0 && word_count_r == '0 && !rejected_r))
    else $error("string state not cleared at string end");

  a_words_le_scalars: assert property (@(posedge clk) disable iff (!rst_n)
    {2'b00, word_count_r} <= scalar_count_r)
    else $error("word count exceeds scalar count");

  a_word_needs_glyph: assert property (@(posedge clk) disable iff (!rst_n)
    in_word_r |-> seen_r)
    else $error("inside a word with no non-space scalar seen");
`endif

endmodule
`default_nettype wire
